FILE: rtl/core/nrp_pkg.sv
// nrp_pkg: shared constants, types and codes of the no-repeat random picker.
// Used by nrp_word_unit and no_repeat_random_picker; depends on nothing.
package nrp_pkg;

	// list size and field widths
	localparam int MAX_ENTRIES = 256;
	localparam int FRAC_W      = 16;
	localparam int CUR_W       = 8;
	localparam int PICK_W      = 8;
	localparam int ECOUNT_W    = 9;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 9;

	// count of entries in use, 0..MAX_ENTRIES
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

	// used map is scanned one word at a time
	localparam int WORD_W    = 16;
	localparam int BIT_W     = $clog2(WORD_W);
	localparam int NUM_WORDS = (MAX_ENTRIES + WORD_W - 1) / WORD_W;
	localparam int WSEL_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int MARK_W    = NUM_WORDS * WORD_W;
	localparam int MIDX_W    = WSEL_W + BIT_W;
	localparam int FCNT_W    = $clog2(WORD_W + 1);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SHUFFLE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT   = 2'd2;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_COUNT  = 7'b0000010,
		S_REFILL = 7'b0000100,
		S_MUL    = 7'b0001000,
		S_SCANW  = 7'b0010000,
		S_SCANB  = 7'b0100000,
		S_DONE   = 7'b1000000
	} state_t;

	// request to the word unit: one word of used marks and where it sits
	typedef struct packed {
		logic [WORD_W-1:0] marks;
		logic [WSEL_W-1:0] sel;
		logic [CNT_W-1:0]  n;
	} word_req_t;

	// free entries of that word below the count, and how many
	typedef struct packed {
		logic [WORD_W-1:0] free;
		logic [FCNT_W-1:0] cnt;
	} word_rsp_t;

endpackage

FILE: rtl/core/nrp_word_unit.sv
// nrp_word_unit: masks one word of the used map to entries below the count
// and counts the free ones. Depends on nrp_pkg.
module nrp_word_unit import nrp_pkg::*; (
	input  word_req_t req,
	output word_rsp_t rsp
);

	localparam int CW = MIDX_W + CNT_W;
	localparam int NIB_W = $clog2(5);

	logic [WORD_W-1:0] free;
	logic [NIB_W-1:0]  nib [WORD_W/4];
	logic [FCNT_W-1:0] total;

	always_comb begin
		logic [MIDX_W-1:0] idx;
		for (int b = 0; b < WORD_W; b++) begin
			idx = {req.sel, BIT_W'(b)};
			free[b] = ~req.marks[b] & (CW'(idx) < CW'(req.n));
		end
	end

	// nibble counts, then a short sum
	always_comb begin
		for (int g = 0; g < WORD_W / 4; g++) begin
			nib[g] = '0;
			for (int j = 0; j < 4; j++) begin
				nib[g] = nib[g] + NIB_W'(free[4*g + j]);
			end
		end
		total = '0;
		for (int g = 0; g < WORD_W / 4; g++) begin
			total = total + FCNT_W'(nib[g]);
		end
	end

	assign rsp.free = free;
	assign rsp.cnt  = total;

endmodule

FILE: rtl/core/no_repeat_random_picker.sv
// no_repeat_random_picker: top level, sequencer, used map and output register.
// Depends on nrp_pkg and nrp_word_unit.
//
// Each input item (rand_fraction, current_known, current_index) yields one
// result item (pick_valid, pick_index). Shuffle mode walks a 256-entry used
// map, 16 entries per cycle, through a single word unit (mask + popcount):
//   - pass 1 looks for any free entry below the count,
//   - an optional refill clears the map but for the last pick, if any,
//   - one 16x9 multiply gives the rank k of the pick,
//   - pass 2 adds up free counts word by word until rank k lies in a word,
//     then that word is searched up to the rank,
//   - the pick is marked used and the done state loads the output register.
// Disabled, zero-entry, single-entry and sequential items go from the idle
// state straight to the done state, with no scan.
// in_ready is high only while the sequencer is idle; one item at a time.
// The result sits in an output register; if the receiver stalls, the next
// item is still accepted and processed, and holds in the done state until
// the output register frees up.
// Reset: enable=1, shuffle_mode=1, entry_count=0, used map clear, no last
// pick. Configuration writes are always taken (cfg_ready is tied high).
module no_repeat_random_picker import nrp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// request channel
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [FRAC_W-1:0]     rand_fraction,
	input  logic                  current_known,
	input  logic [CUR_W-1:0]      current_index,
	// result channel
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  pick_valid,
	output logic [PICK_W-1:0]     pick_index,
	// configuration write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CMP_W = CUR_W + CNT_W + MIDX_W;
	localparam int SUM_W = CNT_W + 1;
	localparam int PROD_W = FRAC_W + CNT_W;
	localparam logic [WSEL_W-1:0] LAST_WORD = WSEL_W'(NUM_WORDS - 1);
	localparam logic [BIT_W-1:0]  LAST_BIT  = BIT_W'(WORD_W - 1);

	// control state
	state_t              state_q;
	logic                out_valid_q;
	logic                enable_q;
	logic                shuffle_q;
	logic [ECOUNT_W-1:0] entry_count_q;
	logic [MARK_W-1:0]   marks_q;
	logic [CNT_W-1:0]    unused_q;
	logic                last_valid_q;
	logic [MIDX_W-1:0]   last_index_q;

	// per-item working registers
	logic [FRAC_W-1:0]   frac_q;
	logic                known_q;
	logic [CUR_W-1:0]    cur_q;
	logic [CNT_W-1:0]    n_q;
	logic [CNT_W-1:0]    k_q;
	logic [CNT_W-1:0]    seen_q;
	logic [WSEL_W-1:0]   word_q;
	logic [WSEL_W-1:0]   last_word_q;
	logic [BIT_W-1:0]    bit_q;
	logic [FCNT_W-1:0]   r_q;
	logic [MIDX_W-1:0]   found_q;
	logic                res_valid_q;
	logic [MIDX_W-1:0]   res_idx_q;
	logic                pick_valid_q;
	logic [MIDX_W-1:0]   pick_index_q;

	word_req_t           wreq;
	word_rsp_t           wrsp;

	logic [CNT_W-1:0]    n_in;
	logic                known_in;
	logic [MIDX_W-1:0]   seq_pick;
	logic                hit;
	logic                eff_lv;
	logic [MIDX_W-1:0]   eff_li;
	logic                eff_mark;
	logic [PROD_W-1:0]   prod;
	logic                out_load;

	// active count, clamped to the map size
	assign n_in = (CMP_W'(entry_count_q) < CMP_W'(MAX_ENTRIES)) ?
		CNT_W'(entry_count_q) : CNT_W'(MAX_ENTRIES);
	// a current index at or past the count counts as unknown
	assign known_in = current_known & (CMP_W'(current_index) < CMP_W'(n_in));
	// sequential mode: next entry, wrapping
	assign seq_pick = ((CMP_W'(current_index) + CMP_W'(1)) >= CMP_W'(n_in)) ?
		'0 : MIDX_W'(CMP_W'(current_index) + CMP_W'(1));

	// shared word unit: pass 1, pass 2 and the bit search all read word_q
	assign wreq.marks = marks_q[{word_q, BIT_W'(0)} +: WORD_W];
	assign wreq.sel   = word_q;
	assign wreq.n     = n_q;

	nrp_word_unit u_word (
		.req (wreq),
		.rsp (wrsp)
	);

	// rank k falls inside the current word
	assign hit = (SUM_W'(seen_q) + SUM_W'(wrsp.cnt)) > SUM_W'(k_q);

	// refill: an unknown last pick takes the current entry
	assign eff_lv   = last_valid_q | known_q;
	assign eff_li   = last_valid_q ? last_index_q : MIDX_W'(cur_q);
	assign eff_mark = eff_lv & (CMP_W'(eff_li) < CMP_W'(n_q));

	assign prod = PROD_W'(frac_q) * PROD_W'(unused_q);

	assign out_load = (state_q == S_DONE) & (~out_valid_q | out_ready);

	assign in_ready   = (state_q == S_IDLE);
	assign cfg_ready  = 1'b1;
	assign out_valid  = out_valid_q;
	assign pick_valid = pick_valid_q;
	assign pick_index = PICK_W'(pick_index_q);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q      <= 1'b1;
			shuffle_q     <= 1'b1;
			entry_count_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ENABLE:  enable_q      <= cfg_data[0];
				REG_SHUFFLE: shuffle_q     <= cfg_data[0];
				REG_COUNT:   entry_count_q <= ECOUNT_W'(cfg_data);
				default: ;
			endcase
		end
	end

	// sequencer and picker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			out_valid_q  <= 1'b0;
			marks_q      <= '0;
			unused_q     <= '0;
			last_valid_q <= 1'b0;
			last_index_q <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DONE;
						if (!enable_q) begin
							// disabled: state untouched
						end else if (n_in == '0) begin
							last_valid_q <= 1'b0;
							last_index_q <= '0;
						end else if (shuffle_q && n_in >= CNT_W'(2)) begin
							state_q <= S_COUNT;
						end else if (shuffle_q) begin
							// one entry: always entry 0
							last_valid_q <= 1'b1;
							last_index_q <= '0;
						end else if (known_in) begin
							last_valid_q <= 1'b1;
							last_index_q <= seq_pick;
						end else begin
							last_valid_q <= 1'b0;
							last_index_q <= '0;
						end
					end
				end
				S_COUNT: begin
					if (wrsp.cnt != '0) begin
						state_q <= (unused_q == '0) ? S_REFILL : S_MUL;
					end else if (word_q == LAST_WORD) begin
						state_q <= S_REFILL;
					end
				end
				S_REFILL: begin
					if (eff_mark) begin
						marks_q  <= MARK_W'(1) << eff_li;
						unused_q <= n_q - CNT_W'(1);
					end else begin
						marks_q  <= '0;
						unused_q <= n_q;
					end
					last_valid_q <= eff_lv;
					last_index_q <= eff_li;
					state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_SCANW;
				end
				S_SCANW: begin
					if (hit || word_q == LAST_WORD) begin
						state_q <= S_SCANB;
					end
				end
				S_SCANB: begin
					if ((wrsp.free[bit_q] && r_q == '0) || bit_q == LAST_BIT) begin
						state_q <= S_DONE;
						// found_q is not yet updated for this bit; the pick is marked below
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			// shuffle pick: mark it once, on entry to the done state
			if (state_q == S_SCANB &&
				((wrsp.free[bit_q] && r_q == '0) || bit_q == LAST_BIT)) begin
				if (wrsp.free[bit_q]) begin
					marks_q[{word_q, bit_q}] <= 1'b1;
					last_index_q <= {word_q, bit_q};
				end else begin
					marks_q[found_q] <= 1'b1;
					last_index_q <= found_q;
				end
				last_valid_q <= 1'b1;
				if (unused_q != '0) begin
					unused_q <= unused_q - CNT_W'(1);
				end
			end
		end
	end

	// per-item datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					frac_q  <= rand_fraction;
					known_q <= known_in;
					cur_q   <= current_index;
					n_q     <= n_in;
					word_q  <= '0;
					if (!enable_q || n_in == '0) begin
						res_valid_q <= 1'b0;
						res_idx_q   <= '0;
					end else if (shuffle_q) begin
						res_valid_q <= 1'b1;
						res_idx_q   <= '0;
					end else if (known_in) begin
						res_valid_q <= 1'b1;
						res_idx_q   <= seq_pick;
					end else begin
						res_valid_q <= 1'b0;
						res_idx_q   <= '0;
					end
				end
			end
			S_COUNT: begin
				word_q <= word_q + WSEL_W'(1);
			end
			S_MUL: begin
				// rank of the pick among free entries
				k_q         <= prod[FRAC_W +: CNT_W];
				word_q      <= '0;
				seen_q      <= '0;
				last_word_q <= '0;
			end
			S_SCANW: begin
				bit_q <= '0;
				if (wrsp.cnt != '0) begin
					last_word_q <= word_q;
				end
				if (hit) begin
					r_q <= FCNT_W'(k_q - seen_q);
				end else if (word_q == LAST_WORD) begin
					// stale count: take the last free entry there is
					r_q <= '1;
					if (wrsp.cnt == '0) begin
						word_q <= last_word_q;
					end
				end else begin
					seen_q <= seen_q + CNT_W'(wrsp.cnt);
					word_q <= word_q + WSEL_W'(1);
				end
			end
			S_SCANB: begin
				bit_q <= bit_q + BIT_W'(1);
				if (wrsp.free[bit_q]) begin
					found_q <= {word_q, bit_q};
					if (r_q != '0) begin
						r_q <= r_q - FCNT_W'(1);
					end
				end
				if ((wrsp.free[bit_q] && r_q == '0) || bit_q == LAST_BIT) begin
					res_valid_q <= 1'b1;
					res_idx_q   <= wrsp.free[bit_q] ? {word_q, bit_q} : found_q;
				end
			end
			S_DONE: begin
				if (out_load) begin
					pick_valid_q <= res_valid_q;
					pick_index_q <= res_idx_q;
				end
			end
			default: ;
		endcase
	end

endmodule

FILE: tb/tb_no_repeat_random_picker.sv
// tb_no_repeat_random_picker: self-checking testbench of the no-repeat random picker.
// It predicts every pick with its own copy of the used map and configuration.
// Depends on nrp_pkg and the no_repeat_random_picker RTL.
module tb_no_repeat_random_picker import nrp_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	// one expected result item
	typedef struct packed {
		logic              pick_valid;
		logic [PICK_W-1:0] pick_index;
	} pick_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [FRAC_W-1:0]     rand_fraction;
	logic                  current_known;
	logic [CUR_W-1:0]      current_index;
	logic                  out_valid;
	logic                  out_ready;
	logic                  pick_valid;
	logic [PICK_W-1:0]     pick_index;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// predictor copy of the configuration registers
	logic                  cfg_enable;
	logic                  cfg_shuffle;
	logic [ECOUNT_W-1:0]   cfg_count;

	// predictor copy of the picker state
	logic [MAX_ENTRIES-1:0] used_map;
	logic [ECOUNT_W-1:0]    unused_cnt;
	logic                   last_ok;
	logic [PICK_W-1:0]      last_pick;

	// picks still owed by the block, oldest first
	pick_t expected_picks[$];

	int mismatch_count;
	int send_idle_pct;
	int recv_idle_pct;
	// set by a test to make the receiver hold off for that many cycles
	int hold_request;

	no_repeat_random_picker dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.rand_fraction (rand_fraction),
		.current_known (current_known),
		.current_index (current_index),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.pick_valid    (pick_valid),
		.pick_index    (pick_index),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// hard limit: a correct run ends far sooner
	initial begin
		#8_000_000;
		$display("Verification failed");
		$finish;
	end

	// ---------------------------------------------------------------------
	// Predictor. Works out the result of one request and advances the state.
	// ---------------------------------------------------------------------
	function automatic pick_t predict_pick(input logic [FRAC_W-1:0] frac,
			input logic known_in, input logic [CUR_W-1:0] cur);
		pick_t r;
		int    n;
		int    k;
		int    seen;
		int    found;
		int    free_cnt;
		int    pick;
		logic  known;
		logic  ok;

		r = '0;
		known = known_in;
		pick = 0;
		ok = 1'b0;
		// disabled: no pick and the state stays as it is
		if (!cfg_enable)
			return r;
		n = (cfg_count < MAX_ENTRIES) ? int'(cfg_count) : MAX_ENTRIES;
		// an index past the list end counts as unknown
		if (int'(cur) >= n)
			known = 1'b0;

		if (n == 0) begin
			ok = 1'b0;
		end else if (cfg_shuffle) begin
			if (n >= 2) begin
				free_cnt = 0;
				for (int i = 0; i < n; i++)
					if (!used_map[i])
						free_cnt++;
				// refill once the list is used up (or the count says so)
				if (unused_cnt == 0 || free_cnt == 0) begin
					used_map = '0;
					if (!last_ok && known) begin
						last_ok = 1'b1;
						last_pick = cur;
					end
					// the last pick sits out the first draw of the new round
					if (last_ok && int'(last_pick) < n) begin
						used_map[last_pick] = 1'b1;
						unused_cnt = ECOUNT_W'(n - 1);
					end else begin
						unused_cnt = ECOUNT_W'(n);
					end
				end
				k = (int'(frac) * int'(unused_cnt)) >>> FRAC_W;
				// k-th free entry; a stale count falls back on the last free one
				seen = 0;
				found = 0;
				for (int i = 0; i < n; i++) begin
					if (!used_map[i]) begin
						found = i;
						if (seen == k)
							break;
						seen++;
					end
				end
				used_map[found] = 1'b1;
				if (unused_cnt > 0)
					unused_cnt--;
				pick = found;
			end else begin
				// single entry: random pick, stepping past the current one
				pick = (int'(frac) * n) >>> FRAC_W;
				if (known && int'(cur) == pick)
					pick = (pick + 1 >= n) ? 0 : pick + 1;
			end
			ok = 1'b1;
		end else if (known) begin
			// sequential: next after the current entry, wrapping to zero
			pick = (int'(cur) + 1 >= n) ? 0 : int'(cur) + 1;
			ok = 1'b1;
		end

		last_ok = ok;
		last_pick = ok ? PICK_W'(pick) : '0;
		r.pick_valid = ok;
		r.pick_index = ok ? PICK_W'(pick) : '0;
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// Receiver: random stalls, plus a long counted hold-off on request.
	// ---------------------------------------------------------------------
	initial begin
		int hold_left;
		hold_left = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// ---------------------------------------------------------------------
	// Result checker: every accepted item against the oldest expected pick.
	// ---------------------------------------------------------------------
	always @(posedge clk) begin : result_check
		pick_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_picks.size() == 0) begin
				$error("unexpected result item: pick_valid %0d pick_index %0d",
					pick_valid, pick_index);
				mismatch_count++;
			end else begin
				want = expected_picks.pop_front();
				if (pick_valid !== want.pick_valid) begin
					$error("pick_valid: expected %0d, got %0d", want.pick_valid, pick_valid);
					mismatch_count++;
				end
				if (pick_index !== want.pick_index) begin
					$error("pick_index: expected %0d, got %0d", want.pick_index, pick_index);
					mismatch_count++;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Shared driver tasks
	// ---------------------------------------------------------------------

	// Offer one request and log its expected pick once accepted.
	// Leaves in_valid high so back-to-back items need no bubble.
	task automatic send_req(input logic [FRAC_W-1:0] frac, input logic known,
			input logic [CUR_W-1:0] cur);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		rand_fraction <= frac;
		current_known <= known;
		current_index <= cur;
		do @(posedge clk); while (!in_ready);
		expected_picks.push_back(predict_pick(frac, known, cur));
	endtask

	task automatic end_burst();
		in_valid <= 1'b0;
	endtask

	// wait for every owed pick, then let the sequencer settle
	task automatic wait_idle();
		while (expected_picks.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(value);
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_ENABLE:  cfg_enable  = value[0];
			REG_SHUFFLE: cfg_shuffle = value[0];
			REG_COUNT:   cfg_count   = ECOUNT_W'(value);
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// request with fields spread over their whole range, biased to the list
	task automatic send_random_item();
		int                n;
		int                r;
		logic [FRAC_W-1:0] frac;
		logic [CUR_W-1:0]  cur;
		n = (cfg_count < MAX_ENTRIES) ? int'(cfg_count) : MAX_ENTRIES;
		r = $urandom_range(99);
		frac = (r < 5) ? '0 : (r < 10) ? '1 : FRAC_W'($urandom);
		if (n > 0 && $urandom_range(99) < 70)
			cur = CUR_W'($urandom_range(n - 1, 0));
		else
			cur = CUR_W'($urandom);
		send_req(frac, $urandom_range(99) < 75, cur);
	endtask

	task automatic pick_random_setting();
		int r;
		int cnt;
		r = $urandom_range(99);
		if (r < 10)      cnt = $urandom_range(1, 0);
		else if (r < 45) cnt = $urandom_range(8, 2);
		else if (r < 75) cnt = $urandom_range(40, 9);
		else if (r < 85) cnt = $urandom_range(255, 41);
		else if (r < 95) cnt = MAX_ENTRIES;
		else             cnt = $urandom_range(511, 257);
		write_reg(REG_ENABLE, ($urandom_range(99) < 8) ? 0 : 1);
		write_reg(REG_SHUFFLE, ($urandom_range(99) < 75) ? 1 : 0);
		write_reg(REG_COUNT, cnt);
	endtask

	// ---------------------------------------------------------------------
	// Directed tests
	// ---------------------------------------------------------------------

	// after reset the list is empty: no pick whatever comes in
	task automatic test_empty_list();
		send_req('0, 1'b1, '0);
		send_req('1, 1'b1, '1);
		end_burst();
		wait_idle();
	endtask

	// one entry: random pick, stepping past the current one wraps to zero
	task automatic test_single_entry();
		write_reg(REG_COUNT, 1);
		send_req('1, 1'b0, '0);
		send_req('0, 1'b1, '0);
		send_req(16'h8000, 1'b1, 8'd200);
		end_burst();
		wait_idle();
	endtask

	// small list drawn dry, then refilled with the last pick left out
	task automatic test_shuffle_refill();
		write_reg(REG_COUNT, 3);
		send_req('0, 1'b1, 8'd1);
		send_req('1, 1'b0, 8'd2);
		send_req(16'h8000, 1'b1, 8'd0);
		send_req('1, 1'b1, 8'd2);
		end_burst();
		wait_idle();
	endtask

	// count changed in the middle of a round: unused count goes stale
	task automatic test_stale_count();
		write_reg(REG_COUNT, 6);
		send_req('1, 1'b0, '0);
		send_req('1, 1'b1, 8'd5);
		end_burst();
		wait_idle();
		write_reg(REG_COUNT, 2);
		send_req('1, 1'b1, 8'd1);
		end_burst();
		wait_idle();
	endtask

	// largest list, then a count above the maximum that gets clamped
	task automatic test_full_list();
		write_reg(REG_COUNT, MAX_ENTRIES);
		send_req('1, 1'b1, 8'd255);
		send_req('0, 1'b0, 8'd255);
		end_burst();
		wait_idle();
		write_reg(REG_COUNT, 511);
		send_req('1, 1'b1, 8'd128);
		end_burst();
		wait_idle();
	endtask

	// sequential: wrap at the end, unknown and out-of-range give no pick
	task automatic test_sequential();
		write_reg(REG_SHUFFLE, 0);
		write_reg(REG_COUNT, 5);
		send_req(16'h1234, 1'b1, 8'd4);
		send_req(16'hFEDC, 1'b1, 8'd0);
		send_req('0, 1'b0, 8'd2);
		send_req('1, 1'b1, 8'd9);
		end_burst();
		wait_idle();
		write_reg(REG_SHUFFLE, 1);
	endtask

	// disabled: nothing picked and the used map left alone
	task automatic test_disabled();
		write_reg(REG_ENABLE, 0);
		send_req('1, 1'b1, 8'd1);
		send_req('0, 1'b0, 8'd3);
		end_burst();
		wait_idle();
		write_reg(REG_ENABLE, 1);
	endtask

	// long receiver hold-off: output register and sequencer fill, input stalls
	task automatic test_output_backpressure();
		int save_send;
		save_send = send_idle_pct;
		send_idle_pct = 0;
		write_reg(REG_COUNT, 40);
		hold_request = 400;
		repeat (8) send_random_item();
		end_burst();
		wait_idle();
		send_idle_pct = save_send;
	endtask

	// ---------------------------------------------------------------------
	// Random test: a full 256-entry round plus many short random settings.
	// ---------------------------------------------------------------------
	task automatic test_random_phase(input int sender_pct, input int receiver_pct,
			input int budget);
		int sent;
		int chunk;
		send_idle_pct = sender_pct;
		recv_idle_pct = receiver_pct;
		// full list, long enough to pass through a refill
		write_reg(REG_ENABLE, 1);
		write_reg(REG_SHUFFLE, 1);
		write_reg(REG_COUNT, MAX_ENTRIES);
		repeat (270) send_random_item();
		end_burst();
		wait_idle();
		sent = 270;
		while (sent < budget) begin
			pick_random_setting();
			chunk = $urandom_range(60, 20);
			repeat (chunk) send_random_item();
			end_burst();
			wait_idle();
			sent += chunk;
		end
	endtask

	// ---------------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------------
	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		rand_fraction = '0;
		current_known = 1'b0;
		current_index = '0;
		cfg_valid     = 1'b0;
		cfg_index     = REG_ENABLE;
		cfg_data      = '0;
		hold_request  = 0;
		mismatch_count = 0;
		send_idle_pct = 30;
		recv_idle_pct = 86;

		// predictor reset state matches the block's
		cfg_enable  = 1'b1;
		cfg_shuffle = 1'b1;
		cfg_count   = '0;
		used_map    = '0;
		unused_cnt  = '0;
		last_ok     = 1'b0;
		last_pick   = '0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_list();
		test_single_entry();
		test_shuffle_refill();
		test_stale_count();
		test_full_list();
		test_sequential();
		test_disabled();
		test_output_backpressure();

		test_random_phase(30, 86, 620);
		test_random_phase(86, 30, 620);
		test_random_phase(0, 0, 620);

		wait_idle();
		repeat (64) @(posedge clk);
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

FILE: files.f
rtl/core/nrp_pkg.sv
rtl/core/nrp_word_unit.sv
rtl/core/no_repeat_random_picker.sv
tb/tb_no_repeat_random_picker.sv
